// File: hw/rtl/adrr_pkg.sv
// Shared types and constants for the allow/deny range rule table.
// Request/response payload structs, function codes, rule flag bits, chain token.
// No dependencies.
`default_nettype none

package adrr_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned ProvW  = 10;
  localparam int unsigned VarW   = 8;
  localparam int unsigned FlagW  = 7;
  localparam int unsigned FreedW = 5;

  // Rule flag bit positions
  localparam int unsigned FLG_ALL    = 0;
  localparam int unsigned FLG_UNCOND = 1;
  localparam int unsigned FLG_PLO    = 2;
  localparam int unsigned FLG_PHI    = 3;
  localparam int unsigned FLG_VLO    = 4;
  localparam int unsigned FLG_VHI    = 5;
  localparam int unsigned FLG_ALLOW  = 6;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [ProvW-1:0]  prov;
    logic [VarW-1:0]   var_req;
    logic              var_known;
    logic              booked;
    logic [ProvW-1:0]  prov_upper;
    logic [VarW-1:0]   var_upper;
    logic [FlagW-1:0]  rule_flags;
  } req_t;

  typedef struct packed {
    logic              skipped;
    logic              status;
    logic [FreedW-1:0] freed_count;
  } rsp_t;

  // Token handed from cell to cell; freed count travels beside it
  typedef struct packed {
    logic valid;
    req_t req;
    logic allow_hit;
    logic deny_hit;
    logic placed;
  } tok_t;

endpackage

`default_nettype wire

// File: hw/rtl/adrr_cell.sv
// One rule slot of the chain: holds a rule and updates the passing token.
// Depends on adrr_pkg.
`default_nettype none

module adrr_cell #(
  parameter int unsigned CntW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire adrr_pkg::tok_t  tok_i,
  input  wire logic [CntW-1:0] cnt_i,
  output adrr_pkg::tok_t       tok_o,
  output logic      [CntW-1:0] cnt_o
);
  import adrr_pkg::*;

  logic             valid_q, valid_d;
  logic [FlagW-1:0] flags_q;
  logic [ProvW-1:0] plo_q, phi_q;
  logic [VarW-1:0]  vlo_q, vhi_q;
  logic             store;
  logic             hit;
  logic [FlagW-1:0] new_flags;
  tok_t             tok_q, tok_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    logic p_lo_eq, p_hi_eq;
    p_lo_eq = (tok_i.req.prov == plo_q);
    p_hi_eq = (tok_i.req.prov == phi_q);
    hit = valid_q;
    if (!flags_q[FLG_ALL]) begin
      if (flags_q[FLG_PLO] && tok_i.req.prov < plo_q) hit = 1'b0;
      if (flags_q[FLG_PHI] && tok_i.req.prov > phi_q) hit = 1'b0;
      if (tok_i.req.var_known) begin
        if (flags_q[FLG_PLO] && p_lo_eq && flags_q[FLG_VLO] && tok_i.req.var_req < vlo_q)
          hit = 1'b0;
        if (flags_q[FLG_PHI] && p_hi_eq && flags_q[FLG_VHI] && tok_i.req.var_req > vhi_q)
          hit = 1'b0;
      end else begin
        if (flags_q[FLG_PLO] && p_lo_eq && flags_q[FLG_VLO]) hit = 1'b0;
        if (flags_q[FLG_PHI] && p_hi_eq && flags_q[FLG_VHI]) hit = 1'b0;
      end
    end
  end

  always_comb begin
    new_flags = tok_i.req.rule_flags;
    if (new_flags[FLG_ALLOW]) new_flags[FLG_UNCOND] = 1'b0;
  end

  always_comb begin
    tok_d   = tok_i;
    cnt_d   = cnt_i;
    valid_d = valid_q;
    store   = 1'b0;
    if (tok_i.valid) begin
      unique case (tok_i.req.func)
        FUNC_ADD: begin
          // first empty slot takes the rule
          if (!valid_q && !tok_i.placed) begin
            store        = 1'b1;
            valid_d      = 1'b1;
            tok_d.placed = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          if (valid_q) cnt_d = cnt_i + CntW'(1);
          valid_d = 1'b0;
        end
        FUNC_QUERY: begin
          if (hit) begin
            if (flags_q[FLG_ALLOW]) tok_d.allow_hit = 1'b1;
            else if (flags_q[FLG_UNCOND] || !tok_i.req.booked) tok_d.deny_hit = 1'b1;
          end
        end
        FUNC_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
      cnt_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && store) begin
      flags_q <= new_flags;
      plo_q   <= tok_i.req.prov;
      phi_q   <= tok_i.req.prov_upper;
      vlo_q   <= tok_i.req.var_req;
      vhi_q   <= tok_i.req.var_upper;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

// File: hw/rtl/allow_deny_range_rule_match.sv
// Channel  | dir | handshake            | payload
// in       | in  | in_valid_i/in_stall_o | adrr_pkg::req_t (add, clear, query)
// out      | out | out_valid_o/out_stall_i | adrr_pkg::rsp_t (one per request)
//
// A request walks the chain of Entries rule cells, one cell per cycle while the
// chain advances, and its response is then registered in the output register;
// the next request is taken once that response is in the output register.
// Reset clears all rule valid bits and the chain at once; no sweep is needed.
// A response held by out_stall_i freezes the chain only if the next one is
// ready to leave it.
// Depends on adrr_pkg and adrr_cell.
`default_nettype none

module allow_deny_range_rule_match #(
  parameter int unsigned Entries = adrr_pkg::ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire adrr_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output adrr_pkg::rsp_t     out_rsp_o
);
  import adrr_pkg::*;

  localparam int unsigned CntW = $clog2(Entries + 1);

  tok_t            tok [Entries+1];
  logic [CntW-1:0] cnt [Entries+1];
  logic            adv;
  logic            busy_q;
  logic            out_valid_q;
  rsp_t            out_rsp_q, rsp_d;
  tok_t            tail;
  logic [CntW+FreedW-1:0] freed_ext;

  assign tail = tok[Entries];

  // hold the chain while a finished request cannot enter the output register
  assign adv = !(tail.valid && out_valid_q && out_stall_i);

  assign tok[0] = '{valid: in_valid_i && !busy_q, req: in_req_i,
                    allow_hit: 1'b0, deny_hit: 1'b0, placed: 1'b0};
  assign cnt[0] = '0;

  for (genvar g = 0; g < Entries; g++) begin : g_cell
    adrr_cell #(.CntW(CntW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .cnt_i  (cnt[g]),
      .tok_o  (tok[g+1]),
      .cnt_o  (cnt[g+1])
    );
  end

  assign freed_ext = {{FreedW{1'b0}}, cnt[Entries]};

  always_comb begin
    rsp_d             = '0;
    rsp_d.skipped     = (tail.req.func == FUNC_QUERY) && tail.deny_hit && !tail.allow_hit;
    rsp_d.status      = (tail.req.func == FUNC_ADD) && !tail.placed;
    rsp_d.freed_count = (tail.req.func == FUNC_CLEAR) ? freed_ext[FreedW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok[0].valid) busy_q <= 1'b1;
      else if (tail.valid && adv) busy_q <= 1'b0;
      if (tail.valid && adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid && adv) out_rsp_q <= rsp_d;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// File: hw/rtl/adrr_chk.sv
// Port-level checks for allow_deny_range_rule_match, bound to the top level.
// Depends on adrr_pkg.
`default_nettype none

module adrr_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire adrr_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire adrr_pkg::rsp_t out_rsp_o
);

  // one request at a time: an accepted request closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // a fresh response frees the chain for the next request
  a_free_on_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("chain still busy when response appeared");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // a full-table refusal carries no other result
  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status |-> !out_rsp_o.skipped && out_rsp_o.freed_count == '0)
    else $error("full status mixed with another result");

endmodule

bind allow_deny_range_rule_match adrr_chk u_adrr_chk (.*);

`default_nettype wire
